FILE: design/plbe_pkg.sv
package plbe_pkg;

   // command codes
   localparam logic [1:0] CMD_EDGE = 2'd0;
   localparam logic [1:0] CMD_TICK = 2'd1;
   localparam logic [1:0] CMD_SEND = 2'd2;

   // receive phases (0..7 are data bits)
   localparam logic [3:0] PH_PARITY   = 4'd8;
   localparam logic [3:0] PH_STOP     = 4'd9;
   localparam logic [3:0] PH_REST     = 4'd10;
   localparam logic [3:0] PH_TIMEOUT  = 4'd11;
   localparam logic [3:0] PH_TIMEOUT2 = 4'd12;

   // transmit edge counts
   localparam logic [3:0] TX_START_COUNT = 4'd10;
   localparam logic [3:0] TX_END         = 4'd0;
   localparam logic [3:0] TX_RELEASE     = 4'd1;
   localparam logic [3:0] TX_PARITY      = 4'd2;

   typedef struct packed {
      logic [1:0] command;
      logic       data_bit;
      logic [7:0] send_data;
   } plbe_item_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       rx_valid;
      logic       rx_error;
      logic       drive_enable;
      logic       drive_level;
      logic       tx_done;
      logic       link_idle;
   } plbe_result_type;

endpackage

FILE: design/plbe_if.sv
interface plbe_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic       data_bit;
   logic [7:0] send_data;

   modport source (output valid, output command, output data_bit, output send_data,
                   input ready);
   modport sink   (input valid, input command, input data_bit, input send_data,
                   output ready);
endinterface

interface plbe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       rx_valid;
   logic       rx_error;
   logic       drive_enable;
   logic       drive_level;
   logic       tx_done;
   logic       link_idle;

   modport source (output valid, output rx_byte, output rx_valid, output rx_error,
                   output drive_enable, output drive_level, output tx_done,
                   output link_idle, input ready);
   modport sink   (input valid, input rx_byte, input rx_valid, input rx_error,
                   input drive_enable, input drive_level, input tx_done,
                   input link_idle, output ready);
endinterface

FILE: design/ps2_link_bit_engine_core.sv
// PS/2 host link bit engine.
// req_chan carries one word per keyboard clock falling edge (command edge,
// with the sampled data line), per recovery tick, or per send request
// (with the byte to transmit). rsp_chan returns exactly one word for every
// request word: received byte with valid or error flags, the data line drive
// enable and level, a transmit done flag and a link idle flag.
// Both channels use a valid/ready handshake; a word moves when both are high.
// A request word is held in the request register and, when it advances,
// passes the next-state logic into the response register. Throughput is
// one word per cycle while the response side does not stall, set by the
// single state update per word in the engine.
// When the response side stalls, the response register holds its word and
// the request register keeps one more; req_chan.ready drops only when both
// are full.
// Reset is synchronous: the receiver returns to rest, transmission stops,
// the data line is released and both registers are emptied.
module ps2_link_bit_engine_core (
   input  logic clock,
   input  logic reset,
   plbe_req_if.sink   req_chan,
   plbe_rsp_if.source rsp_chan
);
   import plbe_pkg::*;

   plbe_item_type   item_ff;
   logic            item_valid_ff;
   plbe_result_type result;
   plbe_result_type rsp_ff;
   logic            rsp_valid_ff;
   logic            advance;
   logic            req_take;

   assign advance  = item_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !item_valid_ff || advance;

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         item_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.command   <= req_chan.command;
         item_ff.data_bit  <= req_chan.data_bit;
         item_ff.send_data <= req_chan.send_data;
      end
   end

   plbe_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (item_ff),
      .result  (result)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.rx_byte      = rsp_ff.rx_byte;
   assign rsp_chan.rx_valid     = rsp_ff.rx_valid;
   assign rsp_chan.rx_error     = rsp_ff.rx_error;
   assign rsp_chan.drive_enable = rsp_ff.drive_enable;
   assign rsp_chan.drive_level  = rsp_ff.drive_level;
   assign rsp_chan.tx_done      = rsp_ff.tx_done;
   assign rsp_chan.link_idle    = rsp_ff.link_idle;

`ifndef SYNTHESIS
   // a frame is never both good and bad
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.rx_valid && rsp_ff.rx_error))
      else $error("rx_valid and rx_error both set");

   // end of transmission leaves the link idle and released
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.tx_done) |-> (rsp_ff.link_idle && !rsp_ff.drive_enable))
      else $error("tx_done without idle released link");

   // a held request word is not dropped while the response side stalls
   assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && !advance) |=> item_valid_ff)
      else $error("request word lost during stall");

   // a stalled response word stays valid
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> rsp_valid_ff)
      else $error("response word lost during stall");
`endif

endmodule

FILE: design/plbe_engine.sv
module plbe_engine (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  plbe_pkg::plbe_item_type  item,
   output plbe_pkg::plbe_result_type result
);
   import plbe_pkg::*;

   logic [3:0] rx_phase_ff,    rx_phase_in;
   logic [7:0] rx_shift_ff,    rx_shift_in;
   logic       parity_acc_ff,  parity_acc_in;
   logic       sending_ff,     sending_in;
   logic [7:0] tx_shift_ff,    tx_shift_in;
   logic [3:0] tx_count_ff,    tx_count_in;
   logic       drive_en_ff,    drive_en_in;
   logic       drive_lvl_ff,   drive_lvl_in;
   logic [7:0] byte_out;
   logic       valid_out;
   logic       error_out;
   logic       done_out;

   // next state for one word
   always_comb begin
      rx_phase_in   = rx_phase_ff;
      rx_shift_in   = rx_shift_ff;
      parity_acc_in = parity_acc_ff;
      sending_in    = sending_ff;
      tx_shift_in   = tx_shift_ff;
      tx_count_in   = tx_count_ff;
      drive_en_in   = drive_en_ff;
      drive_lvl_in  = drive_lvl_ff;
      byte_out      = 8'd0;
      valid_out     = 1'b0;
      error_out     = 1'b0;
      done_out      = 1'b0;
      case (item.command)
         CMD_EDGE: begin
            if (!sending_ff) begin
               // receive frame
               case (rx_phase_ff)
                  PH_STOP: begin
                     if (item.data_bit) begin
                        byte_out    = rx_shift_ff;
                        valid_out   = 1'b1;
                        rx_phase_in = PH_REST;
                     end else begin
                        error_out   = 1'b1;
                        rx_phase_in = PH_TIMEOUT;
                     end
                  end
                  PH_PARITY: begin
                     parity_acc_in = parity_acc_ff ^ item.data_bit;
                     if (parity_acc_in) begin
                        rx_phase_in = PH_STOP;
                     end else begin
                        error_out   = 1'b1;
                        rx_phase_in = PH_TIMEOUT;
                     end
                  end
                  PH_REST: begin
                     if (!item.data_bit) begin
                        rx_phase_in   = 4'd0;
                        parity_acc_in = 1'b0;
                     end else begin
                        error_out   = 1'b1;
                        rx_phase_in = PH_TIMEOUT;
                     end
                  end
                  PH_TIMEOUT, PH_TIMEOUT2: begin
                  end
                  default: begin
                     // data bit, lsb first
                     rx_shift_in   = {item.data_bit, rx_shift_ff[7:1]};
                     parity_acc_in = parity_acc_ff ^ item.data_bit;
                     rx_phase_in   = rx_phase_ff + 4'd1;
                  end
               endcase
            end else begin
               // transmit frame
               case (tx_count_ff)
                  TX_END: begin
                     rx_phase_in   = PH_REST;
                     sending_in    = 1'b0;
                     parity_acc_in = 1'b0;
                     done_out      = 1'b1;
                  end
                  TX_RELEASE: begin
                     drive_en_in  = 1'b0;
                     drive_lvl_in = 1'b0;
                  end
                  TX_PARITY: begin
                     drive_en_in  = 1'b1;
                     drive_lvl_in = parity_acc_ff;
                  end
                  default: begin
                     drive_en_in   = 1'b1;
                     drive_lvl_in  = tx_shift_ff[0];
                     parity_acc_in = parity_acc_ff ^ tx_shift_ff[0];
                     tx_shift_in   = {1'b0, tx_shift_ff[7:1]};
                  end
               endcase
               tx_count_in = tx_count_ff - 4'd1;
            end
         end
         CMD_TICK: begin
            if (rx_phase_ff == PH_TIMEOUT) begin
               rx_phase_in = PH_TIMEOUT2;
            end else if (rx_phase_ff == PH_TIMEOUT2) begin
               rx_phase_in = PH_REST;
            end
         end
         CMD_SEND: begin
            tx_shift_in   = item.send_data;
            tx_count_in   = TX_START_COUNT;
            parity_acc_in = 1'b1;
            sending_in    = 1'b1;
            drive_en_in   = 1'b1;
            drive_lvl_in  = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // result fields
   always_comb begin
      result.rx_byte      = byte_out;
      result.rx_valid     = valid_out;
      result.rx_error     = error_out;
      result.drive_enable = drive_en_in;
      result.drive_level  = drive_lvl_in;
      result.tx_done      = done_out;
      result.link_idle    = (rx_phase_in == PH_REST) && !sending_in;
   end

   // link state
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_phase_ff   <= PH_REST;
         rx_shift_ff   <= 8'd0;
         parity_acc_ff <= 1'b0;
         sending_ff    <= 1'b0;
         tx_shift_ff   <= 8'd0;
         tx_count_ff   <= 4'd0;
         drive_en_ff   <= 1'b0;
         drive_lvl_ff  <= 1'b0;
      end else if (step_en) begin
         rx_phase_ff   <= rx_phase_in;
         rx_shift_ff   <= rx_shift_in;
         parity_acc_ff <= parity_acc_in;
         sending_ff    <= sending_in;
         tx_shift_ff   <= tx_shift_in;
         tx_count_ff   <= tx_count_in;
         drive_en_ff   <= drive_en_in;
         drive_lvl_ff  <= drive_lvl_in;
      end
   end

endmodule
